// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, quiet while reset is high
`define PTA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent check that also runs through reset
`define PTA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/pta_pkg.sv
// ----------------------------------------------------------------------------
// pta_pkg
// Types, constants and helpers for the pan/tilt aiming kinematics pipeline.
// ----------------------------------------------------------------------------
package pta_pkg;

   localparam int NS    = 16;  // cordic iterations per chain
   localparam int PW    = 20;  // position field width
   localparam int AGW   = 17;  // output angle width
   localparam int CW    = 34;  // cordic x/y datapath width
   localparam int AW    = 27;  // internal angle width, 1/65536 degree
   localparam int IDX_W = 5;
   localparam int LW    = 12;  // link length width
   localparam int PRW   = 48;  // length by trig product width
   localparam int DW    = 56;  // magnitude gain product width
   localparam int QW    = 2 * CW;

   typedef logic signed [CW-1:0]  cw_type;
   typedef logic signed [AW-1:0]  ang_type;
   typedef logic signed [PW-1:0]  pos_type;
   typedef logic signed [AGW-1:0] angle_type;
   typedef logic [LW-1:0]         len_type;
   typedef logic signed [PRW-1:0] prod_type;
   typedef logic signed [DW-1:0]  wide_type;
   typedef logic signed [QW-1:0]  quad_type;

   localparam ang_type   DEG90        = 27'sd5898240;
   localparam ang_type   DEG180       = 27'sd11796480;
   localparam cw_type    INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [20:0] INV_GAIN_Q20 = 21'sd636751;
   localparam angle_type ANG_LIMIT    = 17'sd46080;

   // register indexes
   localparam logic [2:0] REG_BASE_X   = 3'd0;
   localparam logic [2:0] REG_BASE_Y   = 3'd1;
   localparam logic [2:0] REG_BASE_Z   = 3'd2;
   localparam logic [2:0] REG_LINK_H   = 3'd3;
   localparam logic [2:0] REG_LINK_OFS = 3'd4;
   localparam logic [2:0] REG_LINK_CAM = 3'd5;

   // data that rides along with an item through every stage
   typedef struct packed {
      pos_type tx;
      pos_type ty;
      pos_type tz;
      ang_type pan;
      ang_type tilt;
      cw_type  sp;
      cw_type  cp;
   } side_type;

   typedef struct packed {
      logic     zero;
      cw_type   x;
      cw_type   y;
      ang_type  z;
      side_type side;
   } vec_type;

   typedef struct packed {
      logic     neg;
      cw_type   x;
      cw_type   y;
      ang_type  z;
      side_type side;
   } rot_type;

   // arctangent of 2^-i in 1/65536 degree
   function automatic ang_type atan_lut(input logic [IDX_W-1:0] i);
      ang_type a;
      case (i)
         5'd0:    a = 27'sd2949120;
         5'd1:    a = 27'sd1740967;
         5'd2:    a = 27'sd919879;
         5'd3:    a = 27'sd466945;
         5'd4:    a = 27'sd234379;
         5'd5:    a = 27'sd117304;
         5'd6:    a = 27'sd58666;
         5'd7:    a = 27'sd29335;
         5'd8:    a = 27'sd14668;
         5'd9:    a = 27'sd7334;
         5'd10:   a = 27'sd3667;
         5'd11:   a = 27'sd1833;
         5'd12:   a = 27'sd917;
         5'd13:   a = 27'sd458;
         5'd14:   a = 27'sd229;
         5'd15:   a = 27'sd115;
         5'd16:   a = 27'sd57;
         5'd17:   a = 27'sd29;
         5'd18:   a = 27'sd14;
         5'd19:   a = 27'sd7;
         5'd20:   a = 27'sd4;
         5'd21:   a = 27'sd2;
         5'd22:   a = 27'sd1;
         default: a = '0;
      endcase
      return a;
   endfunction

   // fold the left half plane onto the right one before vectoring
   function automatic vec_type vec_prep(input cw_type x, input cw_type y,
                                        input side_type s);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.side = s;
      if (x < 0) begin
         v.x = -x;
         v.y = -y;
         v.z = (y >= 0) ? DEG180 : -DEG180;
      end else begin
         v.x = x;
         v.y = y;
         v.z = '0;
      end
      return v;
   endfunction

   // bring the angle into +-90 degrees, remember the sign flip
   function automatic rot_type rot_prep(input ang_type z, input side_type s);
      rot_type r;
      r.side = s;
      r.x    = INV_GAIN_Q30;
      r.y    = '0;
      if (z > DEG90) begin
         r.z   = z - DEG180;
         r.neg = 1'b1;
      end else if (z < -DEG90) begin
         r.z   = z + DEG180;
         r.neg = 1'b1;
      end else begin
         r.z   = z;
         r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic pos_type sat_pos(input cw_type v);
      cw_type hi;
      cw_type lo;
      hi = cw_type'((64'sd1 <<< (PW - 1)) - 64'sd1);
      lo = -cw_type'(64'sd1 <<< (PW - 1));
      if (v > hi)
         return pos_type'(hi);
      else if (v < lo)
         return pos_type'(lo);
      return pos_type'(v);
   endfunction

   function automatic angle_type sat_ang(input ang_type v);
      if (v > ang_type'(ANG_LIMIT))
         return ANG_LIMIT;
      else if (v < -ang_type'(ANG_LIMIT))
         return -ANG_LIMIT;
      return angle_type'(v);
   endfunction

endpackage

// File: hw/rtl/pta_ifs.sv
// ----------------------------------------------------------------------------
// pta channel interfaces
// Target request, aim response and register write channels.
// ----------------------------------------------------------------------------
interface pta_req_if;
   import pta_pkg::*;
   logic    valid;
   logic    ready;
   pos_type target_x;
   pos_type target_y;
   pos_type target_z;
   modport source (output valid, target_x, target_y, target_z, input ready);
   modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface pta_rsp_if;
   import pta_pkg::*;
   logic      valid;
   logic      ready;
   angle_type pan_angle;
   angle_type tilt_angle;
   pos_type   end_x;
   pos_type   end_y;
   pos_type   end_z;
   modport source (output valid, pan_angle, tilt_angle, end_x, end_y, end_z,
                   input ready);
   modport sink   (input valid, pan_angle, tilt_angle, end_x, end_y, end_z,
                   output ready);
endinterface

interface pta_csr_if;
   import pta_pkg::*;
   logic          valid;
   logic          ready;
   logic [2:0]    index;
   logic [PW-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pta_vec_cell.sv
// ----------------------------------------------------------------------------
// pta_vec_cell
// One vectoring cordic iteration: drives y toward zero, sums the angle.
// ----------------------------------------------------------------------------
module pta_vec_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [pta_pkg::IDX_W-1:0] idx,
   input  logic                      in_valid,
   input  pta_pkg::vec_type          in_data,
   output logic                      out_valid,
   output pta_pkg::vec_type          out_data
);
   import pta_pkg::*;

   vec_type cell_ff, cell_in;
   logic    valid_ff;
   cw_type  dx, dy;
   ang_type da;

   // shift-add step, direction from the sign of y
   always_comb begin
      dx      = in_data.y >>> idx;
      dy      = in_data.x >>> idx;
      da      = atan_lut(idx);
      cell_in = in_data;
      if (in_data.y >= 0) begin
         cell_in.x = in_data.x + dx;
         cell_in.y = in_data.y - dy;
         cell_in.z = in_data.z + da;
      end else begin
         cell_in.x = in_data.x - dx;
         cell_in.y = in_data.y + dy;
         cell_in.z = in_data.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (en)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en)
         cell_ff <= cell_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = cell_ff;
endmodule

// File: hw/rtl/pta_rot_cell.sv
// ----------------------------------------------------------------------------
// pta_rot_cell
// One rotation cordic iteration: turns the vector, drives the angle to zero.
// ----------------------------------------------------------------------------
module pta_rot_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic [pta_pkg::IDX_W-1:0] idx,
   input  logic                      in_valid,
   input  pta_pkg::rot_type          in_data,
   output logic                      out_valid,
   output pta_pkg::rot_type          out_data
);
   import pta_pkg::*;

   rot_type cell_ff, cell_in;
   logic    valid_ff;
   cw_type  dx, dy;
   ang_type da;

   // shift-add step, direction from the sign of the residual angle
   always_comb begin
      dx      = in_data.y >>> idx;
      dy      = in_data.x >>> idx;
      da      = atan_lut(idx);
      cell_in = in_data;
      if (in_data.z >= 0) begin
         cell_in.x = in_data.x - dx;
         cell_in.y = in_data.y + dy;
         cell_in.z = in_data.z - da;
      end else begin
         cell_in.x = in_data.x + dx;
         cell_in.y = in_data.y - dy;
         cell_in.z = in_data.z + da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else if (en)
         valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en)
         cell_ff <= cell_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = cell_ff;
endmodule

// File: hw/rtl/pan_tilt_aim_kinematics.sv
// A request beat is registered through setup, cordic chain and multiply stages to the response.
// Throughput: one target per cycle while the response is not stalled; five chains of cordic cells set the depth.
// A stalled response holds the whole pipeline and drops req ready.
// Reset clears every stage valid and loads the default mount geometry.
// ----------------------------------------------------------------------------
// pan_tilt_aim_kinematics
// Pan/tilt servo angles for a target point and the camera end position,
// built as a pipeline of cordic cell chains with multiply stages between.
// ----------------------------------------------------------------------------
module pan_tilt_aim_kinematics (
   input logic       clock,
   input logic       reset,
   pta_req_if.sink   req_chan,
   pta_rsp_if.source rsp_chan,
   pta_csr_if.sink   csr_chan
);
   import pta_pkg::*;

   // geometry registers
   pos_type base_x_ff, base_y_ff, base_z_ff;
   len_type l1_ff, l2_ff, l3_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff <= pos_type'(0);
         base_y_ff <= pos_type'(-8000);
         base_z_ff <= pos_type'(-12480);
         l1_ff     <= len_type'(1104);
         l2_ff     <= len_type'(168);
         l3_ff     <= len_type'(1248);
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_BASE_X:   base_x_ff <= csr_chan.data;
            REG_BASE_Y:   base_y_ff <= csr_chan.data;
            REG_BASE_Z:   base_z_ff <= csr_chan.data;
            REG_LINK_H:   l1_ff     <= csr_chan.data[LW-1:0];
            REG_LINK_OFS: l2_ff     <= csr_chan.data[LW-1:0];
            REG_LINK_CAM: l3_ff     <= csr_chan.data[LW-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: hold everything while the response waits
   logic out_v_ff;
   logic en;
   assign en             = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // chain wiring
   vec_type c1_d [0:NS];
   logic    c1_v [0:NS];
   rot_type c2_d [0:NS];
   logic    c2_v [0:NS];
   vec_type c3_d [0:NS];
   logic    c3_v [0:NS];
   vec_type c4_d [0:NS];
   logic    c4_v [0:NS];
   rot_type c5_d [0:NS];
   logic    c5_v [0:NS];

   // stage registers
   vec_type  p1_ff, p1_in;
   rot_type  r1_ff, r1_in;
   side_type m0_ff, m0_in;
   side_type m1_s_ff;
   prod_type m1_pa_ff, m1_pa_in, m1_pb_ff, m1_pb_in;
   side_type m2_s_ff;
   cw_type   m2_a_ff, m2_a_in, m2_b_ff, m2_b_in;
   vec_type  v2_ff, v2_in;
   side_type d0_s_ff;
   cw_type   d0_mag_ff, d0_mag_in;
   side_type d1_s_ff;
   wide_type d1_p_ff, d1_p_in;
   side_type d2_s_ff;
   cw_type   d2_dist_ff, d2_dist_in, d2_h_ff, d2_h_in;
   vec_type  v3_ff, v3_in;
   side_type t0_ff, t0_in;
   rot_type  t1_ff, t1_in;
   side_type f0_s_ff;
   cw_type   f0_ct_ff, f0_ct_in, f0_st_ff, f0_st_in;
   side_type f1_s_ff;
   prod_type f1_pst_ff, f1_pst_in, f1_pc1_ff, f1_pc1_in, f1_pc2_ff, f1_pc2_in;
   side_type f2_s_ff;
   cw_type   f2_r16_ff, f2_r16_in, f2_ez_ff, f2_ez_in;
   side_type f3_s_ff;
   cw_type   f3_ez_ff;
   quad_type f3_qx_ff, f3_qx_in, f3_qy_ff, f3_qy_in;
   angle_type out_pan_ff, out_pan_in, out_tilt_ff, out_tilt_in;
   pos_type   out_ex_ff, out_ex_in, out_ey_ff, out_ey_in, out_ez_ff, out_ez_in;
   logic p1_v_ff, r1_v_ff, m0_v_ff, m1_v_ff, m2_v_ff, v2_v_ff;
   logic d0_v_ff, d1_v_ff, d2_v_ff, v3_v_ff, t0_v_ff, t1_v_ff;
   logic f0_v_ff, f1_v_ff, f2_v_ff, f3_v_ff;

   side_type req_side, r1_side;
   ang_type  pan_w, tilt_w;
   logic [LW:0] l13;

   // pan vector setup: x = ty - by, y = bx - tx
   always_comb begin
      req_side    = '0;
      req_side.tx = req_chan.target_x;
      req_side.ty = req_chan.target_y;
      req_side.tz = req_chan.target_z;
      p1_in = vec_prep(cw_type'(req_chan.target_y) - cw_type'(base_y_ff),
                       cw_type'(base_x_ff) - cw_type'(req_chan.target_x),
                       req_side);
   end

   assign c1_d[0] = p1_ff;
   assign c1_v[0] = p1_v_ff;
   for (genvar i = 0; i < NS; i++) begin : g_c1
      pta_vec_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .idx(IDX_W'(i)),
         .in_valid(c1_v[i]), .in_data(c1_d[i]),
         .out_valid(c1_v[i+1]), .out_data(c1_d[i+1])
      );
   end

   // pan angle, then sine/cosine setup
   always_comb begin
      pan_w       = c1_d[NS].zero ? '0 : c1_d[NS].z;
      r1_side     = c1_d[NS].side;
      r1_side.pan = pan_w;
      r1_in       = rot_prep(pan_w, r1_side);
   end

   assign c2_d[0] = r1_ff;
   assign c2_v[0] = r1_v_ff;
   for (genvar i = 0; i < NS; i++) begin : g_c2
      pta_rot_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .idx(IDX_W'(i)),
         .in_valid(c2_v[i]), .in_data(c2_d[i]),
         .out_valid(c2_v[i+1]), .out_data(c2_d[i+1])
      );
   end

   // planar distance components
   always_comb begin
      m0_in    = c2_d[NS].side;
      m0_in.sp = c2_d[NS].neg ? -c2_d[NS].y : c2_d[NS].y;
      m0_in.cp = c2_d[NS].neg ? -c2_d[NS].x : c2_d[NS].x;
      m1_pa_in = $signed({1'b0, l1_ff}) * m0_ff.sp;
      m1_pb_in = $signed({1'b0, l2_ff}) * m0_ff.cp;
      m2_a_in  = ((cw_type'(base_x_ff) - cw_type'(m1_s_ff.tx)) <<< 8)
               - cw_type'((m1_pa_ff + (prod_type'(1) <<< 21)) >>> 22);
      m2_b_in  = ((cw_type'(base_y_ff) - cw_type'(m1_s_ff.ty)) <<< 8)
               - cw_type'((m1_pb_ff + (prod_type'(1) <<< 21)) >>> 22);
      v2_in    = vec_prep(m2_a_ff, m2_b_ff, m2_s_ff);
   end

   assign c3_d[0] = v2_ff;
   assign c3_v[0] = v2_v_ff;
   for (genvar i = 0; i < NS; i++) begin : g_c3
      pta_vec_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .idx(IDX_W'(i)),
         .in_valid(c3_v[i]), .in_data(c3_d[i]),
         .out_valid(c3_v[i+1]), .out_data(c3_d[i+1])
      );
   end

   // gain-corrected distance and height
   always_comb begin
      d0_mag_in  = (c3_d[NS].zero || c3_d[NS].x < 0) ? '0 : c3_d[NS].x;
      d1_p_in    = d0_mag_ff * INV_GAIN_Q20;
      d2_dist_in = cw_type'((d1_p_ff + (wide_type'(1) <<< 19)) >>> 20);
      d2_h_in    = (cw_type'(d1_s_ff.tz) - cw_type'(l1_ff) - cw_type'(base_z_ff)) <<< 8;
      v3_in      = vec_prep(d2_dist_ff, d2_h_ff, d2_s_ff);
   end

   assign c4_d[0] = v3_ff;
   assign c4_v[0] = v3_v_ff;
   for (genvar i = 0; i < NS; i++) begin : g_c4
      pta_vec_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .idx(IDX_W'(i)),
         .in_valid(c4_v[i]), .in_data(c4_d[i]),
         .out_valid(c4_v[i+1]), .out_data(c4_d[i+1])
      );
   end

   // tilt is the complement of the elevation
   always_comb begin
      tilt_w     = c4_d[NS].zero ? '0 : c4_d[NS].z;
      t0_in      = c4_d[NS].side;
      t0_in.tilt = DEG90 - tilt_w;
      t1_in      = rot_prep(t0_ff.tilt, t0_ff);
   end

   assign c5_d[0] = t1_ff;
   assign c5_v[0] = t1_v_ff;
   for (genvar i = 0; i < NS; i++) begin : g_c5
      pta_rot_cell u_cell (
         .clock(clock), .reset(reset), .en(en), .idx(IDX_W'(i)),
         .in_valid(c5_v[i]), .in_data(c5_d[i]),
         .out_valid(c5_v[i+1]), .out_data(c5_d[i+1])
      );
   end

   // forward kinematics
   always_comb begin
      f0_ct_in  = c5_d[NS].neg ? -c5_d[NS].x : c5_d[NS].x;
      f0_st_in  = c5_d[NS].neg ? -c5_d[NS].y : c5_d[NS].y;
      l13       = {1'b0, l1_ff} + {1'b0, l3_ff};
      f1_pst_in = $signed({1'b0, l3_ff}) * f0_st_ff;
      f1_pc1_in = $signed({1'b0, l13}) * f0_ct_ff;
      f1_pc2_in = $signed({1'b0, l2_ff}) * ((cw_type'(1) <<< 30) - f0_ct_ff);
      f2_r16_in = cw_type'(((prod_type'(l2_ff) <<< 30) + f1_pst_ff
                            + (prod_type'(1) <<< 13)) >>> 14);
      f2_ez_in  = cw_type'((f1_pc1_ff + f1_pc2_ff + (prod_type'(1) <<< 29)) >>> 30);
      f3_qx_in  = f2_s_ff.sp * f2_r16_ff;
      f3_qy_in  = f2_s_ff.cp * f2_r16_ff;
      out_ex_in = sat_pos(cw_type'(base_x_ff)
                  + cw_type'((-f3_qx_ff + (quad_type'(1) <<< 45)) >>> 46));
      out_ey_in = sat_pos(cw_type'(base_y_ff)
                  + cw_type'((f3_qy_ff + (quad_type'(1) <<< 45)) >>> 46));
      out_ez_in = sat_pos(cw_type'(base_z_ff) + f3_ez_ff);
      out_pan_in  = sat_ang((f3_s_ff.pan + ang_type'(128)) >>> 8);
      out_tilt_in = sat_ang((f3_s_ff.tilt + ang_type'(128)) >>> 8);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0; r1_v_ff <= 1'b0; m0_v_ff <= 1'b0; m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0; v2_v_ff <= 1'b0; d0_v_ff <= 1'b0; d1_v_ff <= 1'b0;
         d2_v_ff <= 1'b0; v3_v_ff <= 1'b0; t0_v_ff <= 1'b0; t1_v_ff <= 1'b0;
         f0_v_ff <= 1'b0; f1_v_ff <= 1'b0; f2_v_ff <= 1'b0; f3_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff  <= req_chan.valid;
         r1_v_ff  <= c1_v[NS];
         m0_v_ff  <= c2_v[NS];
         m1_v_ff  <= m0_v_ff;
         m2_v_ff  <= m1_v_ff;
         v2_v_ff  <= m2_v_ff;
         d0_v_ff  <= c3_v[NS];
         d1_v_ff  <= d0_v_ff;
         d2_v_ff  <= d1_v_ff;
         v3_v_ff  <= d2_v_ff;
         t0_v_ff  <= c4_v[NS];
         t1_v_ff  <= t0_v_ff;
         f0_v_ff  <= c5_v[NS];
         f1_v_ff  <= f0_v_ff;
         f2_v_ff  <= f1_v_ff;
         f3_v_ff  <= f2_v_ff;
         out_v_ff <= f3_v_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff      <= p1_in;
         r1_ff      <= r1_in;
         m0_ff      <= m0_in;
         m1_s_ff    <= m0_ff;
         m1_pa_ff   <= m1_pa_in;
         m1_pb_ff   <= m1_pb_in;
         m2_s_ff    <= m1_s_ff;
         m2_a_ff    <= m2_a_in;
         m2_b_ff    <= m2_b_in;
         v2_ff      <= v2_in;
         d0_s_ff    <= c3_d[NS].side;
         d0_mag_ff  <= d0_mag_in;
         d1_s_ff    <= d0_s_ff;
         d1_p_ff    <= d1_p_in;
         d2_s_ff    <= d1_s_ff;
         d2_dist_ff <= d2_dist_in;
         d2_h_ff    <= d2_h_in;
         v3_ff      <= v3_in;
         t0_ff      <= t0_in;
         t1_ff      <= t1_in;
         f0_s_ff    <= c5_d[NS].side;
         f0_ct_ff   <= f0_ct_in;
         f0_st_ff   <= f0_st_in;
         f1_s_ff    <= f0_s_ff;
         f1_pst_ff  <= f1_pst_in;
         f1_pc1_ff  <= f1_pc1_in;
         f1_pc2_ff  <= f1_pc2_in;
         f2_s_ff    <= f1_s_ff;
         f2_r16_ff  <= f2_r16_in;
         f2_ez_ff   <= f2_ez_in;
         f3_s_ff    <= f2_s_ff;
         f3_ez_ff   <= f2_ez_ff;
         f3_qx_ff   <= f3_qx_in;
         f3_qy_ff   <= f3_qy_in;
         out_pan_ff  <= out_pan_in;
         out_tilt_ff <= out_tilt_in;
         out_ex_ff   <= out_ex_in;
         out_ey_ff   <= out_ey_in;
         out_ez_ff   <= out_ez_in;
      end
   end

   // response beat
   assign rsp_chan.valid      = out_v_ff;
   assign rsp_chan.pan_angle  = out_pan_ff;
   assign rsp_chan.tilt_angle = out_tilt_ff;
   assign rsp_chan.end_x      = out_ex_ff;
   assign rsp_chan.end_y      = out_ey_ff;
   assign rsp_chan.end_z      = out_ez_ff;
endmodule

// File: hw/rtl/pta_checker.sv
// ----------------------------------------------------------------------------
// pta_checker
// Port-level checks on the aiming pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pta_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input pta_pkg::angle_type pan_angle,
   input pta_pkg::angle_type tilt_angle,
   input pta_pkg::pos_type   end_x,
   input pta_pkg::pos_type   end_y,
   input pta_pkg::pos_type   end_z
);
   import pta_pkg::*;

   logic [2*AGW+3*PW-1:0] rsp_word;
   logic                  rsp_stall;
   logic                  pan_ok;
   logic                  tilt_ok;

   // response payload as one word, stall and range flags
   assign rsp_word  = {pan_angle, tilt_angle, end_x, end_y, end_z};
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign pan_ok    = (pan_angle <= ANG_LIMIT) && (pan_angle >= -ANG_LIMIT);
   assign tilt_ok   = (tilt_angle <= ANG_LIMIT) && (tilt_angle >= -ANG_LIMIT);

   // a waiting response beat holds
   `PTA_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word), "response changed while stalled")

   // angles stay inside the servo range
   `PTA_ASSERT(a_pan_range, clock, reset, rsp_valid |-> pan_ok, "pan angle out of range")
   `PTA_ASSERT(a_tilt_range, clock, reset, rsp_valid |-> tilt_ok, "tilt angle out of range")

   // requests are only held back by a stalled response
   `PTA_ASSERT(a_req_stall, clock, reset, req_valid && !req_ready |-> rsp_stall, "request held, no stall")

   // reset empties the pipeline
   `PTA_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_valid, "response valid right after reset")
endmodule

bind pan_tilt_aim_kinematics pta_checker u_pta_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .pan_angle(rsp_chan.pan_angle),
   .tilt_angle(rsp_chan.tilt_angle),
   .end_x(rsp_chan.end_x),
   .end_y(rsp_chan.end_y),
   .end_z(rsp_chan.end_z)
);
